/* rtl/crps_pkg.sv */
// ----------------------------------------------------------------------------
// crps_pkg
// Shared types and constants for the credit refill process scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package crps_pkg;

  // default table depth
  localparam int unsigned NUM_ENTRIES_DEF = 16;

  // fixed field widths
  localparam int unsigned ENTRY_W  = 4;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned UPTIME_W = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_ENTRY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ENTRY  = 1'd1;

  // configuration reset values
  localparam logic [ENTRY_W-1:0] CLOCK_ENTRY_RST = 4'd1;
  localparam logic [ENTRY_W-1:0] IDLE_ENTRY_RST  = 4'd0;

  // input actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_UPDATE   = 2'd1,
    ACT_RESCHED  = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

endpackage

`default_nettype wire

/* rtl/credit_refill_process_scheduler.sv */
// ----------------------------------------------------------------------------
// credit_refill_process_scheduler
// Credit refill priority scheduler with a sequenced scan over the entry table.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one beat per action: tick,
//   entry update or forced reschedule. Result channel (out_valid / out_stall)
//   returns exactly one beat per input beat: the running entry, uptime and
//   the reschedule / refill / idle flags.
//   The configuration port writes the clock and idle entry indexes; write it
//   only while no beat is in flight.
// Sequencing
//   Update and unused actions: accept, then S_DONE loads the result register.
//   A tick that keeps its entry: S_TICK writes the decremented credit, then S_DONE.
//   A reschedule is a scan pass over the table, optionally followed by a
//   refill pass and a second scan. One credit comparator and one table
//   read port are shared by every pass, so one beat is worked at a time
//   and in_stall stays high until its result is loaded.
// Reset
//   Synchronous: all ready flags and credits read as zero, uptime is zero,
//   the running entry is zero. No clearing pass is needed.
// Back pressure
//   While out_stall holds a result, the finished next result waits inside and
//   no new beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_refill_process_scheduler #(
  parameter int unsigned NUM_ENTRIES = crps_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration port
  input  wire logic                              cfg_we,
  input  wire logic [crps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [crps_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [crps_pkg::ENTRY_W-1:0]      in_entry_index,
  input  wire logic                              in_ready_req,
  input  wire logic [crps_pkg::PRIO_W-1:0]       in_priority_req,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [crps_pkg::ENTRY_W-1:0]           out_chosen_index,
  output logic [crps_pkg::UPTIME_W-1:0]          out_uptime,
  output logic                                   out_rescheduled,
  output logic                                   out_refilled,
  output logic                                   out_idle_fallback
);

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned PW    = IDX_W + 1;
  localparam int unsigned CW    = (IDX_W + 1 > crps_pkg::ENTRY_W + 1) ?
                                  IDX_W + 1 : crps_pkg::ENTRY_W + 1;
  localparam int unsigned EW    = crps_pkg::ENTRY_W;
  localparam int unsigned PRW   = crps_pkg::PRIO_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TICK   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_REFILL = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // control state
  state_t                   state_r, state_nxt;
  logic [PW-1:0]            ptr_r, ptr_nxt;
  logic                     ev_v_r, ev_v_nxt;
  logic [IDX_W-1:0]         ev_k_r, ev_k_nxt;
  logic [PRW-1:0]           best_c_r, best_c_nxt;
  logic [IDX_W-1:0]         best_k_r, best_k_nxt;
  logic                     best_f_r, best_f_nxt;
  logic                     any_r, any_nxt;
  logic                     pass_r, pass_nxt;
  logic                     did_r, did_nxt;
  logic                     refl_r, refl_nxt;
  logic                     idfb_r, idfb_nxt;
  logic [EW-1:0]            running_r, running_nxt;
  logic [crps_pkg::UPTIME_W-1:0] tick_r, tick_nxt;
  logic [EW-1:0]            clock_r, clock_nxt;
  logic [EW-1:0]            idle_r, idle_nxt;
  logic [NUM_ENTRIES-1:0]   ready_r, ready_nxt;
  logic [NUM_ENTRIES-1:0]   cvalid_r, cvalid_nxt;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [EW-1:0]            out_chosen_r, out_chosen_nxt;
  logic [crps_pkg::UPTIME_W-1:0] out_uptime_r, out_uptime_nxt;
  logic                     out_resch_r, out_resch_nxt;
  logic                     out_refl_r, out_refl_nxt;
  logic                     out_idfb_r, out_idfb_nxt;

  // table memories
  logic [PRW-1:0]           cred_mem [NUM_ENTRIES];
  logic [PRW-1:0]           prio_mem [NUM_ENTRIES];
  logic [PRW-1:0]           cred_q_r;
  logic [PRW-1:0]           prio_q_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     cw_en;
  logic [IDX_W-1:0]         cw_addr;
  logic [PRW-1:0]           cw_data;
  logic                     pw_en;
  logic [IDX_W-1:0]         pw_addr;

  // helpers
  logic                     in_acc;
  logic [CW-1:0]            run_ext;
  logic [CW-1:0]            upd_ext;
  logic [CW-1:0]            clock_ext;
  logic [CW-1:0]            idle_ext;
  logic [CW-1:0]            evk_ext;
  logic [CW-1:0]            bestk_ext;
  logic [IDX_W-1:0]         run_idx;
  logic                     run_in_tbl;
  logic                     upd_in_tbl;
  logic                     issue;
  logic                     pass_end;
  logic                     eligible;
  logic [PRW-1:0]           ev_credit;
  logic [PRW-1:0]           run_credit;
  logic [PRW-1:0]           dec_credit;
  logic                     start_scan;
  logic                     scan_pass;

  assign in_acc     = in_valid && !in_stall;
  assign run_ext    = {{(CW-EW){1'b0}}, running_r};
  assign upd_ext    = {{(CW-EW){1'b0}}, in_entry_index};
  assign clock_ext  = {{(CW-EW){1'b0}}, clock_r};
  assign idle_ext   = {{(CW-EW){1'b0}}, idle_r};
  assign evk_ext    = {{(CW-IDX_W){1'b0}}, ev_k_r};
  assign bestk_ext  = {{(CW-IDX_W){1'b0}}, best_k_r};
  assign run_idx    = run_ext[IDX_W-1:0];
  assign run_in_tbl = run_ext < CW'(NUM_ENTRIES);
  assign upd_in_tbl = upd_ext < CW'(NUM_ENTRIES);
  assign issue      = ptr_r < PW'(NUM_ENTRIES);
  assign pass_end   = !issue && !ev_v_r;

  // shared compare path: the entry coming out of the read stage
  assign eligible   = ready_r[ev_k_r] && (evk_ext != clock_ext) && (evk_ext != idle_ext);
  assign ev_credit  = cvalid_r[ev_k_r] ? cred_q_r : '0;
  assign run_credit = cvalid_r[run_idx] ? cred_q_r : '0;
  assign dec_credit = (run_credit != '0) ? run_credit - PRW'(1) : '0;

  // one read address for both tables
  always_comb begin
    if (state_r == S_SCAN || state_r == S_REFILL) begin
      rd_addr = ptr_r[IDX_W-1:0];
    end else begin
      rd_addr = run_idx;
    end
  end

  // credit table
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cred_mem[cw_addr] <= cw_data;
    end
    cred_q_r <= cred_mem[rd_addr];
  end

  // priority table
  always_ff @(posedge clk) begin
    if (pw_en) begin
      prio_mem[pw_addr] <= in_priority_req;
    end
    prio_q_r <= prio_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    ev_v_nxt       = ev_v_r;
    ev_k_nxt       = ev_k_r;
    best_c_nxt     = best_c_r;
    best_k_nxt     = best_k_r;
    best_f_nxt     = best_f_r;
    any_nxt        = any_r;
    pass_nxt       = pass_r;
    did_nxt        = did_r;
    refl_nxt       = refl_r;
    idfb_nxt       = idfb_r;
    running_nxt    = running_r;
    tick_nxt       = tick_r;
    clock_nxt      = clock_r;
    idle_nxt       = idle_r;
    ready_nxt      = ready_r;
    cvalid_nxt     = cvalid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_chosen_nxt = out_chosen_r;
    out_uptime_nxt = out_uptime_r;
    out_resch_nxt  = out_resch_r;
    out_refl_nxt   = out_refl_r;
    out_idfb_nxt   = out_idfb_r;
    cw_en          = 1'b0;
    cw_addr        = ev_k_r;
    cw_data        = prio_q_r;
    pw_en          = 1'b0;
    pw_addr        = upd_ext[IDX_W-1:0];
    start_scan     = 1'b0;
    scan_pass      = 1'b0;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        crps_pkg::CFG_CLOCK_ENTRY: clock_nxt = cfg_wdata;
        crps_pkg::CFG_IDLE_ENTRY:  idle_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          did_nxt  = 1'b0;
          refl_nxt = 1'b0;
          idfb_nxt = 1'b0;
          case (in_action)
            crps_pkg::ACT_TICK: begin
              tick_nxt = tick_r + 1'b1;
              if (run_in_tbl) begin
                state_nxt = S_TICK;
              end else begin
                did_nxt    = 1'b1;
                start_scan = 1'b1;
              end
            end
            crps_pkg::ACT_UPDATE: begin
              if (upd_in_tbl) begin
                ready_nxt[upd_ext[IDX_W-1:0]] = in_ready_req;
                pw_en = 1'b1;
              end
              state_nxt = S_DONE;
            end
            crps_pkg::ACT_RESCHED: begin
              did_nxt    = 1'b1;
              start_scan = 1'b1;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // running entry credit came back: take one, reschedule at zero
      S_TICK: begin
        cw_en   = 1'b1;
        cw_addr = run_idx;
        cw_data = dec_credit;
        cvalid_nxt[run_idx] = 1'b1;
        if (dec_credit == '0) begin
          did_nxt    = 1'b1;
          start_scan = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // best credit search, one entry per cycle
      S_SCAN: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        ev_v_nxt = issue;
        ev_k_nxt = ptr_r[IDX_W-1:0];
        if (ev_v_r && eligible) begin
          any_nxt = 1'b1;
          if (ev_credit > best_c_r) begin
            best_c_nxt = ev_credit;
            best_k_nxt = ev_k_r;
            best_f_nxt = 1'b1;
          end
        end
        if (pass_end) begin
          if (best_f_r) begin
            running_nxt = bestk_ext[EW-1:0];
            state_nxt   = S_DONE;
          end else if (!pass_r) begin
            refl_nxt  = 1'b1;
            ptr_nxt   = '0;
            ev_v_nxt  = 1'b0;
            state_nxt = S_REFILL;
          end else begin
            running_nxt = idle_r;
            idfb_nxt    = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end

      // reload credit of every ready entry from its priority
      S_REFILL: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        ev_v_nxt = issue;
        ev_k_nxt = ptr_r[IDX_W-1:0];
        if (ev_v_r && ready_r[ev_k_r]) begin
          cw_en = 1'b1;
          cvalid_nxt[ev_k_r] = 1'b1;
        end
        if (pass_end) begin
          if (any_r) begin
            start_scan = 1'b1;
            scan_pass  = 1'b1;
          end else begin
            running_nxt = idle_r;
            idfb_nxt    = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = running_r;
          out_uptime_nxt = tick_r;
          out_resch_nxt  = did_r;
          out_refl_nxt   = refl_r;
          out_idfb_nxt   = idfb_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // scan setup
    if (start_scan) begin
      ptr_nxt    = '0;
      ev_v_nxt   = 1'b0;
      best_c_nxt = '0;
      best_k_nxt = '0;
      best_f_nxt = 1'b0;
      pass_nxt   = scan_pass;
      if (!scan_pass) begin
        any_nxt = 1'b0;
      end
      state_nxt  = S_SCAN;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      ev_v_r      <= 1'b0;
      best_f_r    <= 1'b0;
      any_r       <= 1'b0;
      pass_r      <= 1'b0;
      did_r       <= 1'b0;
      refl_r      <= 1'b0;
      idfb_r      <= 1'b0;
      running_r   <= '0;
      tick_r      <= '0;
      clock_r     <= crps_pkg::CLOCK_ENTRY_RST;
      idle_r      <= crps_pkg::IDLE_ENTRY_RST;
      ready_r     <= '0;
      cvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      ev_v_r      <= ev_v_nxt;
      best_f_r    <= best_f_nxt;
      any_r       <= any_nxt;
      pass_r      <= pass_nxt;
      did_r       <= did_nxt;
      refl_r      <= refl_nxt;
      idfb_r      <= idfb_nxt;
      running_r   <= running_nxt;
      tick_r      <= tick_nxt;
      clock_r     <= clock_nxt;
      idle_r      <= idle_nxt;
      ready_r     <= ready_nxt;
      cvalid_r    <= cvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ev_k_r       <= ev_k_nxt;
    best_c_r     <= best_c_nxt;
    best_k_r     <= best_k_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_uptime_r <= out_uptime_nxt;
    out_resch_r  <= out_resch_nxt;
    out_refl_r   <= out_refl_nxt;
    out_idfb_r   <= out_idfb_nxt;
  end

  // ports
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_chosen_index  = out_chosen_r;
  assign out_uptime        = out_uptime_r;
  assign out_rescheduled   = out_resch_r;
  assign out_refilled      = out_refl_r;
  assign out_idle_fallback = out_idfb_r;

  // idle fallback only comes out of a reschedule that refilled
  a_idle_fb_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_idfb_r) |-> (out_resch_r && out_refl_r))
    else $error("idle fallback without reschedule and refill");

  // a refill never happens without a scan
  a_refill_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_resch_r) |-> (!out_refl_r && !out_idfb_r))
    else $error("refill flagged on a beat without a scan");

  // scan pointer never runs past the table depth
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(NUM_ENTRIES))
    else $error("scan pointer past table end");

  // a second scan only starts after a refill pass
  a_second_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && pass_r) |-> refl_r)
    else $error("second scan without refill");

endmodule

`default_nettype wire
